### rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Every macro is clocked on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define FAC_HOLD(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("fac check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define FAC_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fac check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FAC_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fac check failed");

`endif

### rtl/core/fac_pkg.sv
// Package for the allocator: transaction payload types, table entry type,
// status and register index codes, default sizes. No dependencies.
package fac_pkg;

  localparam int AW = 21;
  localparam int HW = 7;

  localparam int MAX_FREE_DEF    = 64;
  localparam int MAX_BLOCKS_DEF  = 64;
  localparam int ARENA_BYTES_DEF = 1048576;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [1:0] CFG_FIT_MODE = 2'd0;
  localparam logic [1:0] CFG_HEADER   = 2'd1;
  localparam logic [1:0] CFG_LIMIT    = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic FIT_FIRST = 1'b0;

  typedef struct packed {
    logic          action;
    logic [AW-1:0] request_size;
    logic [AW-1:0] block_address;
  } in_t;

  typedef struct packed {
    logic [AW-1:0] payload_address;
    logic [2:0]    status;
    logic [AW-1:0] free_bytes;
    logic [AW-1:0] segment_bytes;
  } out_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] length;
  } blk_t;

endpackage

### rtl/core/fac_mem.sv
// Simple dual port table memory: one write and one registered read per cycle.
// Uses no package; depth and width come from the instantiating module.
module fac_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 42
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/fit_allocator_coalescing.sv
// Allocator top level: first-fit / best-fit free-list heap with coalescing.
// Uses fac_pkg, fac_mem and assert_macros.svh.
// One transaction is in work at a time.
// Reset (sync, rst_n low) empties both tables at once; no clearing pass.
module fit_allocator_coalescing #(
  parameter int MAX_FREE    = fac_pkg::MAX_FREE_DEF,
  parameter int MAX_BLOCKS  = fac_pkg::MAX_BLOCKS_DEF,
  parameter int ARENA_BYTES = fac_pkg::ARENA_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  fac_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output fac_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [fac_pkg::AW-1:0]   cfg_wdata
);

  import fac_pkg::*;
  `include "assert_macros.svh"

  localparam int FIW = $clog2(MAX_FREE);
  localparam int FCW = $clog2(MAX_FREE + 1);
  localparam int UIW = $clog2(MAX_BLOCKS);
  localparam int UCW = $clog2(MAX_BLOCKS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_SCAN = 4'd1;  // walk free table for a fit
  localparam logic [3:0] S_A_DEC  = 4'd2;  // split, take whole, or grow top
  localparam logic [3:0] S_F_SCAN = 4'd3;  // walk used table for the address
  localparam logic [3:0] S_F_POS  = 4'd4;  // find insertion point in free table
  localparam logic [3:0] S_F_DEC  = 4'd5;  // merge decision
  localparam logic [3:0] S_SHDN   = 4'd6;  // close a gap in the free table
  localparam logic [3:0] S_SHUP   = 4'd7;  // open a gap in the free table
  localparam logic [3:0] S_INS    = 4'd8;  // write the new free entry
  localparam logic [3:0] S_DONE   = 4'd9;  // hand result to output register

  // Control and configuration state.
  logic [3:0]            state_r, state_nxt;
  logic                  mode_r, mode_nxt;
  logic [HW-1:0]         hdr_r, hdr_nxt;
  logic [AW-1:0]         limit_r, limit_nxt;
  logic [FCW-1:0]        fcnt_r, fcnt_nxt;
  logic [AW-1:0]         top_r, top_nxt;
  logic [AW-1:0]         ftot_r, ftot_nxt;
  logic [MAX_BLOCKS-1:0] uval_r, uval_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers for the transaction in flight.
  logic [AW-1:0]  size_r, size_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [UIW-1:0] slot_r, slot_nxt;
  logic [FCW-1:0] fr_idx_r, fr_idx_nxt;
  logic [FIW-1:0] fc_idx_r, fc_idx_nxt;
  logic [UCW-1:0] ur_idx_r, ur_idx_nxt;
  logic [UIW-1:0] uc_idx_r, uc_idx_nxt;
  logic           found_r, found_nxt;
  logic [AW-1:0]  best_r, best_nxt;
  logic [FIW-1:0] pick_r, pick_nxt;
  logic [AW-1:0]  bst_r, bst_nxt;
  logic [AW-1:0]  blen_r, blen_nxt;
  logic [FCW-1:0] pos_r, pos_nxt;
  logic           hprev_r, hprev_nxt;
  logic           hnext_r, hnext_nxt;
  blk_t           prv_r, prv_nxt;
  blk_t           nxt_r, nxt_nxt;
  logic [2:0]     stat_r, stat_nxt;
  logic [AW-1:0]  paddr_r, paddr_nxt;
  out_t           out_r, out_nxt;

  // Table memory ports.
  logic           f_we;
  logic [FIW-1:0] f_waddr, f_raddr;
  blk_t           f_wdata, f_rd;
  logic [$bits(blk_t)-1:0] f_rdata;
  logic           u_we;
  logic [UIW-1:0] u_waddr, u_raddr;
  blk_t           u_wdata, u_rd;
  logic [$bits(blk_t)-1:0] u_rdata;

  // First unused slot in the used table.
  logic [UIW-1:0] free_slot;
  logic           slot_ok;

  always_comb begin
    free_slot = '0;
    slot_ok   = 1'b0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!uval_r[i]) begin
        free_slot = UIW'(i);
        slot_ok   = 1'b1;
      end
    end
  end

  fac_mem #(.DEPTH(MAX_FREE), .WIDTH($bits(blk_t))) u_free_tbl (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  fac_mem #(.DEPTH(MAX_BLOCKS), .WIDTH($bits(blk_t))) u_used_tbl (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  assign f_rd = blk_t'(f_rdata);
  assign u_rd = blk_t'(u_rdata);

  // Sequencer. Table reads are pipelined one entry per cycle: pend_r marks
  // that read data for index fc_idx_r / uc_idx_r is on the memory output.
  // Shifts read one entry ahead of the write, so a read and a write never
  // hit the same entry in one cycle.
  always_comb begin
    logic [AW-1:0]   hdr21;
    logic            f_can;
    logic            u_can;
    logic            hit;
    logic [AW-1:0]   left;
    logic [AW-1:0]   rem;
    logic [AW+1:0]   newtop;
    logic            mprev;
    logic            mnext;

    hdr21  = AW'(hdr_r);
    f_can  = 1'b0;
    u_can  = 1'b0;
    hit    = 1'b0;
    left   = '0;
    rem    = '0;
    newtop = '0;
    mprev  = 1'b0;
    mnext  = 1'b0;

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    hdr_nxt       = hdr_r;
    limit_nxt     = limit_r;
    fcnt_nxt      = fcnt_r;
    top_nxt       = top_r;
    ftot_nxt      = ftot_r;
    uval_nxt      = uval_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    slot_nxt      = slot_r;
    fr_idx_nxt    = fr_idx_r;
    fc_idx_nxt    = fc_idx_r;
    ur_idx_nxt    = ur_idx_r;
    uc_idx_nxt    = uc_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    bst_nxt       = bst_r;
    blen_nxt      = blen_r;
    pos_nxt       = pos_r;
    hprev_nxt     = hprev_r;
    hnext_nxt     = hnext_r;
    prv_nxt       = prv_r;
    nxt_nxt       = nxt_r;
    stat_nxt      = stat_r;
    paddr_nxt     = paddr_r;
    out_nxt       = out_r;

    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = '0;
    u_we    = 1'b0;
    u_waddr = '0;
    u_wdata = '0;
    u_raddr = '0;

    // Drop the output transaction once the sink takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes; the user must issue them only while the block is idle, the block does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_MODE: mode_nxt  = cfg_wdata[0];
        CFG_HEADER:   hdr_nxt   = cfg_wdata[HW-1:0];
        CFG_LIMIT:    limit_nxt = cfg_wdata;
        default:      ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          size_nxt  = in_data.request_size;
          addr_nxt  = in_data.block_address;
          paddr_nxt = '0;
          pend_nxt  = 1'b0;
          if (in_data.action == ACT_ALLOC) begin
            if (in_data.request_size == '0) begin
              stat_nxt  = ST_NULL;
              state_nxt = S_DONE;
            end else if (!slot_ok) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              slot_nxt   = free_slot;
              fr_idx_nxt = '0;
              found_nxt  = 1'b0;
              state_nxt  = S_A_SCAN;
            end
          end else begin
            if (in_data.block_address == '0) begin
              stat_nxt  = ST_NULL;
              state_nxt = S_DONE;
            end else begin
              ur_idx_nxt = '0;
              state_nxt  = S_F_SCAN;
            end
          end
        end
      end

      S_A_SCAN: begin
        f_can = fr_idx_r < fcnt_r;
        hit   = pend_r && (f_rd.length >= size_r);
        left  = f_rd.length - size_r;
        if (hit && (!found_r || left < best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = left;
          pick_nxt  = fc_idx_r;
          bst_nxt   = f_rd.start;
          blen_nxt  = f_rd.length;
        end
        if ((hit && mode_r == FIT_FIRST) || (!f_can && !pend_r)) begin
          pend_nxt  = 1'b0;
          state_nxt = S_A_DEC;
        end else if (f_can) begin
          f_raddr    = fr_idx_r[FIW-1:0];
          fc_idx_nxt = fr_idx_r[FIW-1:0];
          fr_idx_nxt = fr_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_A_DEC: begin
        if (found_r) begin
          rem       = blen_r - size_r;
          u_we      = 1'b1;
          u_waddr   = slot_r;
          u_wdata.start = bst_r;
          uval_nxt[slot_r] = 1'b1;
          paddr_nxt = bst_r + hdr21;
          stat_nxt  = ST_OK;
          if (rem >= hdr21) begin
            // Split: caller gets the requested size, tail stays free.
            u_wdata.length = size_r;
            f_we           = 1'b1;
            f_waddr        = pick_r;
            f_wdata.start  = bst_r + hdr21 + size_r;
            f_wdata.length = rem - hdr21;
            ftot_nxt       = ftot_r - size_r - hdr21;
            state_nxt      = S_DONE;
          end else begin
            // Hand out the whole block and close its table entry.
            u_wdata.length = blen_r;
            ftot_nxt       = ftot_r - blen_r - hdr21;
            fr_idx_nxt     = FCW'(pick_r) + 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = S_SHDN;
          end
        end else begin
          newtop = {2'b00, top_r} + (AW+2)'(hdr_r) + {2'b00, size_r};
          if (newtop > {2'b00, limit_r} || 32'(newtop) > 32'(ARENA_BYTES)) begin
            stat_nxt = ST_OOM;
          end else begin
            u_we           = 1'b1;
            u_waddr        = slot_r;
            u_wdata.start  = top_r;
            u_wdata.length = size_r;
            uval_nxt[slot_r] = 1'b1;
            paddr_nxt      = top_r + hdr21;
            top_nxt        = newtop[AW-1:0];
            stat_nxt       = ST_OK;
          end
          state_nxt = S_DONE;
        end
      end

      S_SHDN: begin
        f_can = fr_idx_r < fcnt_r;
        if (pend_r) begin
          f_we    = 1'b1;
          f_waddr = fc_idx_r - 1'b1;
          f_wdata = f_rd;
        end
        if (f_can) begin
          f_raddr    = fr_idx_r[FIW-1:0];
          fc_idx_nxt = fr_idx_r[FIW-1:0];
          fr_idx_nxt = fr_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!f_can && !pend_r) begin
          fcnt_nxt  = fcnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_F_SCAN: begin
        u_can = ur_idx_r < UCW'(MAX_BLOCKS);
        hit   = pend_r && uval_r[uc_idx_r] && ((u_rd.start + hdr21) == addr_r);
        if (hit) begin
          slot_nxt   = uc_idx_r;
          bst_nxt    = u_rd.start;
          blen_nxt   = u_rd.length;
          fr_idx_nxt = '0;
          pos_nxt    = '0;
          hprev_nxt  = 1'b0;
          hnext_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = S_F_POS;
        end else if (!u_can && !pend_r) begin
          stat_nxt  = ST_UNKNOWN;
          state_nxt = S_DONE;
        end else if (u_can) begin
          u_raddr    = ur_idx_r[UIW-1:0];
          uc_idx_nxt = ur_idx_r[UIW-1:0];
          ur_idx_nxt = ur_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_F_POS: begin
        f_can = fr_idx_r < fcnt_r;
        if (pend_r && f_rd.start >= bst_r) begin
          nxt_nxt   = f_rd;
          hnext_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_F_DEC;
        end else begin
          if (pend_r) begin
            prv_nxt   = f_rd;
            hprev_nxt = 1'b1;
            pos_nxt   = pos_r + 1'b1;
          end
          if (!f_can && !pend_r) begin
            state_nxt = S_F_DEC;
          end else if (f_can) begin
            f_raddr    = fr_idx_r[FIW-1:0];
            fc_idx_nxt = fr_idx_r[FIW-1:0];
            fr_idx_nxt = fr_idx_r + 1'b1;
            pend_nxt   = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end

      S_F_DEC: begin
        mprev = hprev_r && ((prv_r.start + hdr21 + prv_r.length) == bst_r);
        mnext = hnext_r && ((bst_r + hdr21 + blen_r) == nxt_r.start);
        stat_nxt = ST_OK;
        if (mprev && mnext) begin
          f_we           = 1'b1;
          f_waddr        = FIW'(pos_r - 1'b1);
          f_wdata.start  = prv_r.start;
          f_wdata.length = prv_r.length + hdr21 + blen_r + hdr21 + nxt_r.length;
          fr_idx_nxt     = pos_r + 1'b1;
          pend_nxt       = 1'b0;
          state_nxt      = S_SHDN;
        end else if (mprev) begin
          f_we           = 1'b1;
          f_waddr        = FIW'(pos_r - 1'b1);
          f_wdata.start  = prv_r.start;
          f_wdata.length = prv_r.length + hdr21 + blen_r;
          state_nxt      = S_DONE;
        end else if (mnext) begin
          f_we           = 1'b1;
          f_waddr        = pos_r[FIW-1:0];
          f_wdata.start  = bst_r;
          f_wdata.length = blen_r + hdr21 + nxt_r.length;
          state_nxt      = S_DONE;
        end else if (fcnt_r >= FCW'(MAX_FREE)) begin
          // No neighbor to merge with and no room: the block stays allocated.
          stat_nxt  = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          fr_idx_nxt = fcnt_r;
          pend_nxt   = 1'b0;
          state_nxt  = S_SHUP;
        end
        if (mprev || mnext || fcnt_r < FCW'(MAX_FREE)) begin
          uval_nxt[slot_r] = 1'b0;
          ftot_nxt         = ftot_r + blen_r + hdr21;
        end
      end

      S_SHUP: begin
        f_can = fr_idx_r > pos_r;
        if (pend_r) begin
          f_we    = 1'b1;
          f_waddr = fc_idx_r + 1'b1;
          f_wdata = f_rd;
        end
        if (f_can) begin
          f_raddr    = FIW'(fr_idx_r - 1'b1);
          fc_idx_nxt = FIW'(fr_idx_r - 1'b1);
          fr_idx_nxt = fr_idx_r - 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!f_can && !pend_r) begin
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        f_we           = 1'b1;
        f_waddr        = pos_r[FIW-1:0];
        f_wdata.start  = bst_r;
        f_wdata.length = blen_r;
        fcnt_nxt       = fcnt_r + 1'b1;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free, then load the result.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_nxt.payload_address = paddr_r;
          out_nxt.status          = stat_r;
          out_nxt.free_bytes      = ftot_r;
          out_nxt.segment_bytes   = top_r;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= FIT_FIRST;
      hdr_r       <= HW'(16);
      limit_r     <= AW'(1048576);
      fcnt_r      <= '0;
      top_r       <= '0;
      ftot_r      <= '0;
      uval_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      hdr_r       <= hdr_nxt;
      limit_r     <= limit_nxt;
      fcnt_r      <= fcnt_nxt;
      top_r       <= top_nxt;
      ftot_r      <= ftot_nxt;
      uval_r      <= uval_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r   <= size_nxt;
    addr_r   <= addr_nxt;
    slot_r   <= slot_nxt;
    fr_idx_r <= fr_idx_nxt;
    fc_idx_r <= fc_idx_nxt;
    ur_idx_r <= ur_idx_nxt;
    uc_idx_r <= uc_idx_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    pick_r   <= pick_nxt;
    bst_r    <= bst_nxt;
    blen_r   <= blen_nxt;
    pos_r    <= pos_nxt;
    hprev_r  <= hprev_nxt;
    hnext_r  <= hnext_nxt;
    prv_r    <= prv_nxt;
    nxt_r    <= nxt_nxt;
    stat_r   <= stat_nxt;
    paddr_r  <= paddr_nxt;
    out_r    <= out_nxt;
  end

  // Take a transaction only when no other one is in work.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FAC_HOLD(a_fcnt_bound, fcnt_r <= FCW'(MAX_FREE))
  `FAC_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE)
  `FAC_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)
  `FAC_NEXT(a_one_slot_change, 1'b1, $countones(uval_r) <= $countones($past(uval_r)) + 1)

endmodule

### bench/tb.sv
// Self-checking bench for the coalescing heap allocator (fit_allocator_coalescing).
// Depends on fac_pkg for payload structs, status and register codes; holds its
// own model of the free and used tables to predict every result transaction.
`timescale 1ns / 100ps

module tb;
  import fac_pkg::*;

  localparam int unsigned M21     = 32'h1F_FFFF;
  localparam int          NBLK    = MAX_BLOCKS_DEF;
  localparam int          NFREE   = MAX_FREE_DEF;
  localparam int          SETTLE  = 260;    // idle wait at the end of drain()
  localparam int          DOG_MAX = 20000;  // cycles with no transaction at all

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_FIT_MODE;
  logic [AW-1:0] cfg_wdata = '0;

  fit_allocator_coalescing u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Allocator model: configuration copy plus both tables.
  logic        fit_sel = FIT_FIRST;
  int unsigned hdr_len = 16;
  int unsigned top_limit = ARENA_BYTES_DEF;
  int unsigned fr_start[NFREE];
  int unsigned fr_len[NFREE];
  int unsigned fr_count = 0;
  int unsigned us_start[NBLK];
  int unsigned us_len[NBLK];
  bit          us_live[NBLK];
  int unsigned top = 0;
  int unsigned free_sum = 0;
  int unsigned last_grant = 0;
  int unsigned last_freed = 0;

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   errors = 0;
  bit   no_idle = 1'b0;

  function automatic void drop_free_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fr_count; i++) begin
      fr_start[i] = fr_start[i+1];
      fr_len[i] = fr_len[i+1];
    end
    if (fr_count > 0) fr_count--;
  endfunction

  function automatic out_t predict_allocator(in_t req);
    out_t        res;
    int unsigned size, slot, pick, best, st, len, pos, addr;
    bit          found, mprev, mnext;
    longint unsigned newtop;
    res = '0;
    res.status = ST_OK;
    size = req.request_size;
    addr = req.block_address;
    if (req.action == ACT_ALLOC) begin
      slot = NBLK;
      for (int i = NBLK - 1; i >= 0; i--) if (!us_live[i]) slot = i;
      found = 1'b0; best = 0; pick = 0;
      if (size == 0) res.status = ST_NULL;
      else if (slot == NBLK) res.status = ST_FULL;
      else begin
        for (int unsigned i = 0; i < fr_count; i++) begin
          if (fr_len[i] >= size) begin
            if (!found || fr_len[i] - size < best) begin
              found = 1'b1; best = fr_len[i] - size; pick = i;
            end
            if (fit_sel == FIT_FIRST) break;
          end
        end
        if (found) begin
          st = fr_start[pick];
          len = fr_len[pick];
          if (len - size >= hdr_len) begin
            // split: caller gets exactly size, tail stays free
            fr_start[pick] = (st + hdr_len + size) & M21;
            fr_len[pick] = (len - size - hdr_len) & M21;
            us_len[slot] = size;
            free_sum = (free_sum - size - hdr_len) & M21;
          end else begin
            drop_free_entry(pick);
            us_len[slot] = len;
            free_sum = (free_sum - len - hdr_len) & M21;
          end
          us_start[slot] = st;
          us_live[slot] = 1'b1;
          res.payload_address = AW'((st + hdr_len) & M21);
        end else begin
          newtop = longint'(top) + hdr_len + size;
          if (newtop > top_limit || newtop > ARENA_BYTES_DEF) res.status = ST_OOM;
          else begin
            us_start[slot] = top;
            us_len[slot] = size;
            us_live[slot] = 1'b1;
            res.payload_address = AW'((top + hdr_len) & M21);
            top = 32'(newtop & M21);
          end
        end
      end
      if (res.status == ST_OK) last_grant = res.payload_address;
    end else begin
      slot = NBLK;
      for (int i = NBLK - 1; i >= 0; i--)
        if (us_live[i] && ((us_start[i] + hdr_len) & M21) == addr) slot = i;
      if (addr == 0) res.status = ST_NULL;
      else if (slot == NBLK) res.status = ST_UNKNOWN;
      else begin
        st = us_start[slot];
        len = us_len[slot];
        pos = 0;
        while (pos < fr_count && fr_start[pos] < st) pos++;
        mprev = pos > 0 && ((fr_start[pos-1] + hdr_len + fr_len[pos-1]) & M21) == st;
        mnext = pos < fr_count && ((st + hdr_len + len) & M21) == fr_start[pos];
        if (mprev && mnext) begin
          fr_len[pos-1] = (fr_len[pos-1] + hdr_len + len + hdr_len + fr_len[pos]) & M21;
          drop_free_entry(pos);
        end else if (mprev) begin
          fr_len[pos-1] = (fr_len[pos-1] + hdr_len + len) & M21;
        end else if (mnext) begin
          fr_start[pos] = st;
          fr_len[pos] = (len + hdr_len + fr_len[pos]) & M21;
        end else if (fr_count >= NFREE) begin
          res.status = ST_FULL;
        end else begin
          for (int unsigned i = fr_count; i > pos; i--) begin
            fr_start[i] = fr_start[i-1];
            fr_len[i] = fr_len[i-1];
          end
          fr_start[pos] = st;
          fr_len[pos] = len;
          fr_count++;
        end
        if (res.status == ST_OK) begin
          us_live[slot] = 1'b0;
          free_sum = (free_sum + len + hdr_len) & M21;
          last_freed = addr;
        end
      end
    end
    res.free_bytes = AW'(free_sum);
    res.segment_bytes = AW'(top);
    return res;
  endfunction

  // Driver: present the next pending request, hold it while stalled, and
  // predict the result once the transaction is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_allocator(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 8)) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure unless no_idle is set, compare every result against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.payload_address !== want.payload_address ||
            out_data.status !== want.status ||
            out_data.free_bytes !== want.free_bytes ||
            out_data.segment_bytes !== want.segment_bytes) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
        end
      end
    end
    out_stall <= !no_idle && $urandom_range(0, 99) < 8;
  end

  // Watchdog: end the run if no transaction moves for too long.
  int dog = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_req(logic act, int unsigned size, int unsigned addr);
    in_t r;
    r.action = act;
    r.request_size = AW'(size);
    r.block_address = AW'(addr);
    while (pending_reqs.size() > 0) @(negedge clk);
    pending_reqs.push_back(r);
  endtask

  // Wait until the block has nothing in flight, then let it settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= AW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_MODE) fit_sel = val[0];
    else if (idx == CFG_HEADER) hdr_len = val & 32'h7F;
    else top_limit = val & M21;
  endtask

  task automatic set_mode(logic fit, int unsigned hdr, int unsigned lim);
    drain();
    write_reg(CFG_FIT_MODE, fit);
    write_reg(CFG_HEADER, hdr);
    write_reg(CFG_LIMIT, lim);
  endtask

  task automatic alloc_now(int unsigned size, output int unsigned addr);
    push_req(ACT_ALLOC, size, $urandom & M21);
    drain();
    addr = last_grant;
  endtask

  // One random request; mostly well-formed alloc/free of live blocks.
  task automatic random_req();
    int          r, n;
    int unsigned size, pick;
    r = $urandom_range(0, 99);
    n = 0;
    for (int i = 0; i < NBLK; i++) n += us_live[i];
    if (r < 45 || (r < 85 && n == 0)) begin
      r = $urandom_range(0, 99);
      if (r < 70) size = $urandom_range(1, 128);
      else if (r < 92) size = $urandom_range(129, 4096);
      else size = $urandom & M21;
      push_req(ACT_ALLOC, size, $urandom & M21);
    end else if (r < 85) begin
      pick = $urandom_range(1, n);
      for (int i = 0; i < NBLK; i++) begin
        if (us_live[i]) begin
          pick--;
          if (pick == 0) begin
            push_req(1'b1, $urandom & M21, (us_start[i] + hdr_len) & M21);
            break;
          end
        end
      end
    end else if (r < 92) begin
      push_req(1'b1, $urandom & M21, $urandom & M21);
    end else if (r < 95) begin
      push_req(1'b1, $urandom & M21, 0);
    end else if (r < 97) begin
      push_req(ACT_ALLOC, 0, $urandom & M21);
    end else begin
      push_req(1'b1, $urandom & M21, last_freed);  // likely a double free
    end
  endtask

  initial begin
    int unsigned a1, a2, a3;
    for (int i = 0; i < NBLK; i++) us_live[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: special cases and field extremes.
    set_mode(FIT_FIRST, 16, ARENA_BYTES_DEF);
    push_req(ACT_ALLOC, 0, M21);
    push_req(1'b1, M21, 0);
    alloc_now(100, a1);
    alloc_now(200, a2);
    alloc_now(50, a3);
    push_req(1'b1, 0, 12345);
    push_req(1'b1, 0, a2);
    drain();
    push_req(1'b1, 0, a2);           // double free
    push_req(1'b1, 0, a1);           // merges with the next free block
    push_req(1'b1, 0, a3);           // merges with the previous free block
    push_req(ACT_ALLOC, 20, 0);      // split
    push_req(ACT_ALLOC, M21, 0);     // out of memory
    push_req(ACT_ALLOC, ARENA_BYTES_DEF, 0);
    push_req(1'b1, 0, M21);
    drain();
    alloc_now(40, a1);
    alloc_now(40, a2);
    alloc_now(40, a3);
    push_req(1'b1, 0, a1);
    push_req(1'b1, 0, a3);
    push_req(1'b1, 0, a2);           // merges on both sides
    // Fill the used table and ask once more.
    for (int i = 0; i < NBLK + 1; i++) push_req(ACT_ALLOC, 8, 0);

    // Random phases over several register settings; the first runs without idling.
    no_idle = 1'b1;
    for (int i = 0; i < 180; i++) random_req();
    no_idle = 1'b0;
    set_mode(1'b1, 16, ARENA_BYTES_DEF);
    for (int i = 0; i < 160; i++) random_req();
    set_mode(1'b1, 0, 4096);
    for (int i = 0; i < 160; i++) random_req();
    set_mode(FIT_FIRST, 64, 20000);
    for (int i = 0; i < 160; i++) random_req();
    set_mode(1'b1, 8, 0);
    for (int i = 0; i < 100; i++) random_req();
    set_mode(FIT_FIRST, 1, ARENA_BYTES_DEF);
    for (int i = 0; i < 110; i++) random_req();

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fac_pkg.sv
rtl/core/fac_mem.sv
rtl/core/fit_allocator_coalescing.sv
bench/tb.sv
